>>> rtl/muxed_adc_scan_smoother_top_defines.svh
// ----------------------------------------------------------------------------
// muxed_adc_scan_smoother_top_defines
// assertion macros shared by the scan smoother rtl
// ----------------------------------------------------------------------------
`ifndef MUXED_ADC_SCAN_SMOOTHER_TOP_DEFINES_SVH
`define MUXED_ADC_SCAN_SMOOTHER_TOP_DEFINES_SVH

// same-cycle implication, disabled in reset
`define MAS_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, disabled in reset
`define MAS_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

>>> rtl/mas_pkg.sv
// ----------------------------------------------------------------------------
// mas_pkg
// shared constants, codes and types of the scan smoother
// ----------------------------------------------------------------------------
package mas_pkg;

	localparam int NUM_STRINGS = 4;
	localparam int NUM_POTS    = 16;
	localparam int NUM_CH      = NUM_STRINGS + NUM_POTS;

	localparam int VAL_W    = 10;
	localparam int SMOOTH_W = 4;
	localparam int NUM_W    = VAL_W + SMOOTH_W;
	localparam int WORD_W   = 16;

	localparam int CH_W   = $clog2(NUM_STRINGS + 1);
	localparam int POT_W  = $clog2(NUM_POTS);
	localparam int ADDR_W = $clog2(NUM_CH);

	localparam logic [SMOOTH_W-1:0] SMOOTH_RESET = SMOOTH_W'(4);

	localparam logic MODE_SAMPLE = 1'b0;
	localparam logic MODE_BUTTON = 1'b1;

	typedef enum logic [2:0] {
		KIND_STRING  = 3'd0,
		KIND_KEY     = 3'd1,
		KIND_SPEED   = 3'd2,
		KIND_JOY_X   = 3'd3,
		KIND_JOY_Y   = 3'd4,
		KIND_BUTTONS = 3'd5
	} mas_kind_t;

	typedef struct packed {
		logic idle;
		logic done;
	} mas_smooth_st_t;

	typedef struct packed {
		logic       diff;
		logic [3:0] new_nibble;
		logic [7:0] new_steppers;
		logic [3:0] cur_nibble;
		logic [7:0] cur_steppers;
	} mas_btn_t;

endpackage

>>> rtl/muxed_adc_scan_smoother_top.sv
// ----------------------------------------------------------------------------
// muxed_adc_scan_smoother_top
// converter scan with exponential smoothing and button word remapping
// ----------------------------------------------------------------------------
// One request in, one result out. From acceptance to a valid result, a sample
// request runs as follows: the smoothing unit shifts the 4-bit weight through a
// bit-serial multiply, adds the sample and runs a restoring divide by weight+1
// one quotient bit a cycle, then passes through hand-back and output register.
// A button request goes straight to the emit state and its result is registered
// once the output register is free. The next request is taken once the previous
// result sits in the output register, even if the sink has not yet taken it.
// Configuration writes are always ready and take effect on the next sample.
module muxed_adc_scan_smoother_top
	import mas_pkg::*;
(
	input  logic                clk,
	input  logic                arst_n,
	// request: tuser[0] mode
	input  logic                s_axis_tvalid,
	output logic                s_axis_tready,
	// tdata: [9:0] sample, [25:10] button_word, rest zero
	input  logic [31:0]         s_axis_tdata,
	input  logic [0:0]          s_axis_tuser,
	// result: tuser[2:0] slot_kind
	output logic                m_axis_tvalid,
	input  logic                m_axis_tready,
	// tdata: [1:0] slot_index, [11:2] value, [12] changed, [15:13] next_adc_channel,
	// [19:16] next_pot_select, [20] scan_buttons, [24:21] buttons, [32:25] steppers
	output logic [39:0]         m_axis_tdata,
	output logic [2:0]          m_axis_tuser,
	// smoothing write
	input  logic                cfg_valid,
	output logic                cfg_ready,
	input  logic [SMOOTH_W-1:0] cfg_data
);

	typedef enum logic [1:0] {
		T_IDLE,
		T_CALC,
		T_EMIT
	} state_t;

	typedef struct packed {
		mas_kind_t  kind;
		logic [1:0] index;
		logic [9:0] value;
		logic       changed;
		logic [2:0] next_adc;
		logic [3:0] next_pot;
		logic       scan;
		logic [3:0] buttons;
		logic [7:0] steppers;
	} out_t;

	state_t              state_q;
	logic [SMOOTH_W-1:0] smoothing_q;
	logic [VAL_W-1:0]    store_q [NUM_CH];
	logic [CH_W-1:0]     adc_q;
	logic [POT_W-1:0]    pot_q;
	logic                mode_q;
	logic [WORD_W-1:0]   word_q;
	logic [ADDR_W-1:0]   addr_q;
	logic [VAL_W-1:0]    old_q;
	out_t                out_q;
	logic                out_valid_q;

	logic                in_take;
	logic                out_free;
	logic                emit;
	logic                on_string;
	logic [ADDR_W-1:0]   addr;
	logic                sm_start;
	mas_smooth_st_t      sm_st;
	logic [VAL_W-1:0]    sm_res;
	mas_btn_t            btn_st;
	logic                pot_wrap;
	logic [POT_W-1:0]    pot_next;
	out_t                out_d;

	assign cfg_ready     = 1'b1;
	assign s_axis_tready = (state_q == T_IDLE);
	assign in_take       = s_axis_tvalid && s_axis_tready;
	assign out_free      = !out_valid_q || m_axis_tready;
	assign emit          = (state_q == T_EMIT) && out_free;

	assign on_string = (adc_q < CH_W'(NUM_STRINGS));
	assign addr      = on_string ? ADDR_W'(adc_q)
		: ADDR_W'(NUM_STRINGS) + ADDR_W'(pot_q);
	assign sm_start  = in_take && (s_axis_tuser[0] == MODE_SAMPLE);

	mas_smooth_unit u_smooth (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (sm_start),
		.old_val (store_q[addr]),
		.sample  (s_axis_tdata[VAL_W-1:0]),
		.weight  (smoothing_q),
		.status  (sm_st),
		.result  (sm_res)
	);

	mas_button_map u_buttons (
		.clk    (clk),
		.arst_n (arst_n),
		.word   (word_q),
		.update (emit && (mode_q == MODE_BUTTON)),
		.status (btn_st)
	);

	assign pot_wrap = (pot_q == POT_W'(NUM_POTS - 1));
	assign pot_next = pot_wrap ? '0 : pot_q + POT_W'(1);

	always_comb begin
		out_d          = '0;
		out_d.next_adc = 3'(adc_q);
		out_d.next_pot = 4'(pot_q);
		out_d.buttons  = btn_st.cur_nibble;
		out_d.steppers = btn_st.cur_steppers;
		if (mode_q == MODE_BUTTON) begin
			out_d.kind     = KIND_BUTTONS;
			out_d.changed  = btn_st.diff;
			out_d.buttons  = btn_st.new_nibble;
			out_d.steppers = btn_st.new_steppers;
		end else if (on_string) begin
			out_d.kind     = KIND_STRING;
			out_d.index    = 2'(CH_W'(NUM_STRINGS - 1) - adc_q);
			out_d.value    = sm_res;
			out_d.changed  = (sm_res != old_q);
			out_d.next_adc = 3'(adc_q + CH_W'(1));
		end else begin
			out_d.kind     = mas_kind_t'(3'(KIND_KEY) + 3'(pot_q[1:0]));
			out_d.index    = 2'(pot_q >> 2);
			out_d.value    = {2'b00, sm_res[VAL_W-1:2]};
			out_d.changed  = (sm_res[VAL_W-1:2] != old_q[VAL_W-1:2]);
			out_d.next_pot = 4'(pot_next);
			out_d.next_adc = pot_wrap ? 3'd0 : 3'(NUM_STRINGS);
			out_d.scan     = pot_wrap;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= T_IDLE;
			smoothing_q <= SMOOTH_RESET;
			adc_q       <= '0;
			pot_q       <= '0;
			out_valid_q <= 1'b0;
			mode_q      <= MODE_SAMPLE;
			word_q      <= '0;
			addr_q      <= '0;
			old_q       <= '0;
			out_q       <= '0;
			for (int i = 0; i < NUM_CH; i++) begin
				store_q[i] <= '0;
			end
		end else begin
			if (cfg_valid && cfg_ready) begin
				smoothing_q <= cfg_data;
			end
			if (emit) begin
				out_valid_q <= 1'b1;
			end else if (m_axis_tready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				T_IDLE: begin
					if (in_take) begin
						mode_q  <= s_axis_tuser[0];
						word_q  <= s_axis_tdata[VAL_W +: WORD_W];
						addr_q  <= addr;
						old_q   <= store_q[addr];
						state_q <= (s_axis_tuser[0] == MODE_BUTTON) ? T_EMIT : T_CALC;
					end
				end
				T_CALC: begin
					if (sm_st.done) begin
						state_q <= T_EMIT;
					end
				end
				T_EMIT: begin
					if (out_free) begin
						out_q   <= out_d;
						state_q <= T_IDLE;
						if (mode_q == MODE_SAMPLE) begin
							store_q[addr_q] <= sm_res;
							if (on_string) begin
								adc_q <= adc_q + CH_W'(1);
							end else begin
								pot_q <= pot_next;
								if (pot_wrap) begin
									adc_q <= '0;
								end
							end
						end
					end
				end
				default: begin
					state_q <= T_IDLE;
				end
			endcase
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tuser  = out_q.kind;
	assign m_axis_tdata  = {7'd0, out_q.steppers, out_q.buttons, out_q.scan, out_q.next_pot,
		out_q.next_adc, out_q.changed, out_q.value, out_q.index};

	`include "muxed_adc_scan_smoother_top_defines.svh"

	`MAS_ASSERT_NOW(a_unit_idle, clk, arst_n, state_q == T_IDLE, sm_st.idle,
		"smoothing unit busy while idle")
	`MAS_ASSERT_NOW(a_adc_range, clk, arst_n, 1'b1, adc_q <= CH_W'(NUM_STRINGS),
		"converter channel out of range")
	`MAS_ASSERT_NOW(a_scan_restart, clk, arst_n, out_valid_q && out_q.scan,
		out_q.next_adc == 3'd0 && out_q.next_pot == 4'd0, "scan wrap without restart")

endmodule

>>> rtl/mas_smooth_unit.sv
// ----------------------------------------------------------------------------
// mas_smooth_unit
// bit-serial (old*w + new) / (w + 1): shift-add multiply then restoring divide
// ----------------------------------------------------------------------------
`include "muxed_adc_scan_smoother_top_defines.svh"

module mas_smooth_unit
	import mas_pkg::*;
(
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	input  logic [VAL_W-1:0]    old_val,
	input  logic [VAL_W-1:0]    sample,
	input  logic [SMOOTH_W-1:0] weight,
	output mas_smooth_st_t      status,
	output logic [VAL_W-1:0]    result
);

	localparam int CNT_W = $clog2(VAL_W);
	localparam int BIT_W = $clog2(SMOOTH_W);

	typedef enum logic [1:0] {
		S_IDLE,
		S_MUL,
		S_ADD,
		S_DIV
	} state_t;

	state_t              state_q;
	logic [VAL_W-1:0]    old_q;
	logic [VAL_W-1:0]    smp_q;
	logic [SMOOTH_W-1:0] wgt_q;
	logic [SMOOTH_W:0]   div_q;
	logic [NUM_W-1:0]    acc_q;
	logic [SMOOTH_W-1:0] rem_q;
	logic [VAL_W-1:0]    quo_q;
	logic [CNT_W-1:0]    cnt_q;
	logic                done_q;

	logic [NUM_W-1:0]    sum;
	logic [SMOOTH_W:0]   trial;
	logic                fits;

	assign sum   = acc_q + NUM_W'(smp_q);
	assign trial = {rem_q, acc_q[VAL_W-1]};
	assign fits  = (trial >= div_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			done_q  <= 1'b0;
			cnt_q   <= '0;
			old_q   <= '0;
			smp_q   <= '0;
			wgt_q   <= '0;
			div_q   <= '0;
			acc_q   <= '0;
			rem_q   <= '0;
			quo_q   <= '0;
		end else begin
			done_q <= (state_q == S_DIV) && (cnt_q == '0);
			case (state_q)
				S_IDLE: begin
					if (start) begin
						old_q   <= old_val;
						smp_q   <= sample;
						wgt_q   <= weight;
						div_q   <= {1'b0, weight} + (SMOOTH_W + 1)'(1);
						acc_q   <= '0;
						cnt_q   <= CNT_W'(SMOOTH_W - 1);
						state_q <= S_MUL;
					end
				end
				S_MUL: begin
					acc_q <= {acc_q[NUM_W-2:0], 1'b0}
						+ (wgt_q[cnt_q[BIT_W-1:0]] ? NUM_W'(old_q) : '0);
					cnt_q <= cnt_q - CNT_W'(1);
					if (cnt_q == '0) begin
						state_q <= S_ADD;
					end
				end
				S_ADD: begin
					acc_q   <= sum;
					rem_q   <= sum[NUM_W-1:VAL_W];
					cnt_q   <= CNT_W'(VAL_W - 1);
					state_q <= S_DIV;
				end
				S_DIV: begin
					rem_q <= fits ? SMOOTH_W'(trial - div_q) : trial[SMOOTH_W-1:0];
					acc_q <= {acc_q[NUM_W-2:0], 1'b0};
					quo_q <= {quo_q[VAL_W-2:0], fits};
					cnt_q <= cnt_q - CNT_W'(1);
					if (cnt_q == '0) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign status.idle = (state_q == S_IDLE);
	assign status.done = done_q;
	assign result      = quo_q;

	`MAS_ASSERT_NOW(a_start_idle, clk, arst_n, start, state_q == S_IDLE, "start while busy")
	`MAS_ASSERT_NOW(a_done_idle, clk, arst_n, done_q, state_q == S_IDLE, "done while busy")
	`MAS_ASSERT_NOW(a_rem_range, clk, arst_n, state_q == S_DIV,
		(SMOOTH_W + 1)'(rem_q) < div_q, "remainder not below divisor")
	`MAS_ASSERT_NEXT(a_mul_step, clk, arst_n, state_q == S_MUL && cnt_q == '0,
		state_q == S_ADD, "multiply did not end")

endmodule

>>> rtl/mas_button_map.sv
// ----------------------------------------------------------------------------
// mas_button_map
// holds the last button word and remaps a new one into nibble and stepper byte
// ----------------------------------------------------------------------------
module mas_button_map
	import mas_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic [WORD_W-1:0] word,
	input  logic              update,
	output mas_btn_t          status
);

	logic [WORD_W-1:0] last_q;
	logic [3:0]        nibble_q;
	logic [7:0]        steppers_q;

	logic [3:0]        nibble;
	logic [7:0]        pairs;
	logic [7:0]        steppers;
	logic              diff;

	always_comb begin
		for (int k = 0; k < 4; k++) begin
			nibble[k]       = word[4*k+3];
			pairs[2*k]      = word[4*k];
			pairs[2*k+1]    = word[4*k+1];
		end
		// high bit of each pair ORed into the low bit
		steppers = pairs | ((pairs & 8'hAA) >> 1);
	end

	assign diff = (word != last_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_q     <= '0;
			nibble_q   <= '0;
			steppers_q <= '0;
		end else if (update && diff) begin
			last_q     <= word;
			nibble_q   <= nibble;
			steppers_q <= steppers;
		end
	end

	assign status.diff         = diff;
	assign status.new_nibble   = diff ? nibble : nibble_q;
	assign status.new_steppers = diff ? steppers : steppers_q;
	assign status.cur_nibble   = nibble_q;
	assign status.cur_steppers = steppers_q;

endmodule
